@@ sv/rfa_pkg.sv @@
`default_nettype none
package rfa_pkg;
	localparam int COORD_W = 32;
	localparam int RAD_W   = 24;
	localparam int ACC_W   = 48;
	localparam int SQ_W    = 2 * RAD_W;
	localparam int SSUM_W  = SQ_W + 2;
	localparam int Q_DEPTH = 4;
	localparam int ADDR_W  = 3;

	localparam logic [RAD_W-1:0] RAD_RESET = 24'd131072;
	localparam logic             CMD_START = 1'b0;
	localparam logic [0:0]       REG_RADIUS = 1'b0;

	typedef enum logic [1:0] {
		OP_START,
		OP_SKIP,
		OP_HIT
	} op_t;

	// one queued word: what the back end has to do with it
	typedef struct packed {
		op_t                       op;
		logic                      last;
		logic [2:0]                neg;
		logic [2:0][RAD_W-1:0]     mag;
	} job_t;
endpackage
`default_nettype wire

@@ sv/rfa_front.sv @@
`default_nettype none
module rfa_front import rfa_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      command,
	input  wire logic signed [COORD_W-1:0] coord_x,
	input  wire logic signed [COORD_W-1:0] coord_y,
	input  wire logic signed [COORD_W-1:0] coord_z,
	input  wire logic                      occupied,
	input  wire logic                      last,
	input  wire logic [RAD_W-1:0]          rad,
	input  wire logic                      q_full,
	output logic                           push,
	output job_t                           job
);
	logic signed [COORD_W-1:0] qry_q [3];
	logic signed [COORD_W-1:0] cin [3];
	logic [COORD_W:0]          d [3];
	logic [COORD_W:0]          dmag [3];
	logic [2:0]                near;
	logic                      take;

	always_comb begin
		cin[0] = coord_x;
		cin[1] = coord_y;
		cin[2] = coord_z;
		for (int i = 0; i < 3; i++) begin
			d[i]    = {cin[i][COORD_W-1], cin[i]} - {qry_q[i][COORD_W-1], qry_q[i]};
			dmag[i] = d[i][COORD_W] ? (~d[i] + 1'b1) : d[i];
			near[i] = dmag[i] < {{(COORD_W + 1 - RAD_W){1'b0}}, rad};
			job.mag[i] = dmag[i][RAD_W-1:0];
			job.neg[i] = ~d[i][COORD_W];
		end
		if (command == CMD_START) begin
			job.op = OP_START;
		end else if (occupied && (&near)) begin
			job.op = OP_HIT;
		end else begin
			job.op = OP_SKIP;
		end
		job.last = last;
		take     = in_valid && !q_full;
		// far or empty cells without last produce nothing
		push     = take && (job.op != OP_SKIP || last);
		in_stall = q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) qry_q[i] <= '0;
		end else if (take && command == CMD_START) begin
			for (int i = 0; i < 3; i++) qry_q[i] <= cin[i];
		end
	end
endmodule
`default_nettype wire

@@ sv/rfa_queue.sv @@
`default_nettype none
module rfa_queue import rfa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      wdata,
	output logic      full,
	input  wire logic pop,
	output job_t      rdata,
	output logic      empty
);
	localparam int PW = $clog2(Q_DEPTH);

	job_t          mem_q [Q_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign full  = cnt_q == (PW + 1)'(Q_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW + 1)'(push) - (PW + 1)'(pop);
		end
	end
endmodule
`default_nettype wire

@@ sv/rfa_back.sv @@
`default_nettype none
module rfa_back import rfa_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [RAD_W-1:0]    rad,
	input  wire logic                q_empty,
	input  job_t                     job,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [COORD_W-1:0] field_x,
	output logic signed [COORD_W-1:0] field_y,
	output logic signed [COORD_W-1:0] field_z,
	output logic                     saturated
);
	localparam int F    = FRAC_BITS;
	localparam int DC_W = $clog2(F + 1);
	localparam int RC_W = $clog2(RAD_W);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQR, ST_SUM, ST_ROOT, ST_DIV, ST_MUL, ST_ACC, ST_EMIT
	} state_t;

	state_t                  state_q;
	logic                    last_q;
	logic [2:0]              neg_q;
	logic [RAD_W-1:0]        amag_q [3];
	logic [SQ_W-1:0]         sq_q [3];
	logic [SQ_W-1:0]         rr_q;
	logic [SQ_W-1:0]         s_q;
	logic [RAD_W-1:0]        root_q;
	logic [RAD_W:0]          rt_rem_q;
	logic [RC_W-1:0]         rcnt_q;
	logic [RAD_W-1:0]        dist_q;
	logic [RAD_W:0]          rem_q;
	logic [RAD_W-1:0]        dvs_q;
	logic [F:0]              q_q;
	logic [DC_W-1:0]         dcnt_q;
	logic                    is_scale_q;
	logic [F:0]              scale_q;
	logic [F:0]              unit_q;
	logic [2*F+1:0]          prod_q;
	logic [1:0]              axis_q;
	logic signed [ACC_W-1:0] sum_q [3];
	logic                    out_valid_q;

	logic [SSUM_W-1:0]       s_sum;
	logic [RAD_W+2:0]        rt_rem, rt_trial, rt_diff;
	logic                    rt_ge;
	logic [RAD_W-1:0]        root_nx;
	logic [RAD_W:0]          dv_rem;
	logic                    dv_ge;
	logic [RAD_W:0]          dv_res;
	logic [F:0]              q_nx;
	logic [ACC_W:0]          mag_ext, acc_ext, acc_sum;
	logic signed [ACC_W-1:0] acc_nx;
	logic [1:0]              axis_nx;
	logic signed [COORD_W-1:0] clip_v [3];
	logic [2:0]              clip_s;
	logic                    emit_go;

	always_comb begin
		s_sum = SSUM_W'(sq_q[0]) + SSUM_W'(sq_q[1]) + SSUM_W'(sq_q[2]);

		// one root digit a cycle
		rt_rem   = {rt_rem_q, s_q[SQ_W-1 -: 2]};
		rt_trial = {1'b0, root_q, 2'b01};
		rt_ge    = rt_rem >= rt_trial;
		rt_diff  = rt_ge ? rt_rem - rt_trial : rt_rem;
		root_nx  = {root_q[RAD_W-2:0], rt_ge};

		// restoring divide, first step compares without shift
		dv_rem = (dcnt_q == '0) ? rem_q : {rem_q[RAD_W-1:0], 1'b0};
		dv_ge  = dv_rem >= {1'b0, dvs_q};
		dv_res = dv_ge ? dv_rem - {1'b0, dvs_q} : dv_rem;
		q_nx   = {q_q[F-1:0], dv_ge};

		mag_ext = (ACC_W + 1)'(prod_q[2*F+1:F]);
		acc_ext = {sum_q[axis_q][ACC_W-1], sum_q[axis_q]};
		acc_sum = neg_q[axis_q] ? acc_ext - mag_ext : acc_ext + mag_ext;
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_nx = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_nx = acc_sum[ACC_W-1:0];
		end
		axis_nx = axis_q + 2'd1;

		for (int i = 0; i < 3; i++) begin
			clip_s[i] = !((&sum_q[i][ACC_W-1:COORD_W-1]) || !(|sum_q[i][ACC_W-1:COORD_W-1]));
			if (!clip_s[i]) begin
				clip_v[i] = sum_q[i][COORD_W-1:0];
			end else if (sum_q[i][ACC_W-1]) begin
				clip_v[i] = {1'b1, {(COORD_W-1){1'b0}}};
			end else begin
				clip_v[i] = {1'b0, {(COORD_W-1){1'b1}}};
			end
		end

		emit_go   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
		pop       = (state_q == ST_IDLE) && !q_empty;
		out_valid = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			neg_q       <= '0;
			rr_q        <= '0;
			s_q         <= '0;
			root_q      <= '0;
			rt_rem_q    <= '0;
			rcnt_q      <= '0;
			dist_q      <= '0;
			rem_q       <= '0;
			dvs_q       <= '0;
			q_q         <= '0;
			dcnt_q      <= '0;
			is_scale_q  <= 1'b0;
			scale_q     <= '0;
			unit_q      <= '0;
			prod_q      <= '0;
			axis_q      <= '0;
			field_x     <= '0;
			field_y     <= '0;
			field_z     <= '0;
			saturated   <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				amag_q[i] <= '0;
				sq_q[i]   <= '0;
				sum_q[i]  <= '0;
			end
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						last_q <= job.last;
						neg_q  <= job.neg;
						for (int i = 0; i < 3; i++) amag_q[i] <= job.mag[i];
						unique case (job.op)
							OP_START: begin
								for (int i = 0; i < 3; i++) sum_q[i] <= '0;
								state_q <= job.last ? ST_EMIT : ST_IDLE;
							end
							OP_HIT:  state_q <= ST_SQR;
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_SQR: begin
					for (int i = 0; i < 3; i++) sq_q[i] <= amag_q[i] * amag_q[i];
					rr_q    <= rad * rad;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (s_sum != '0 && s_sum < SSUM_W'(rr_q)) begin
						s_q      <= s_sum[SQ_W-1:0];
						root_q   <= '0;
						rt_rem_q <= '0;
						rcnt_q   <= '0;
						state_q  <= ST_ROOT;
					end else begin
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_ROOT: begin
					s_q      <= {s_q[SQ_W-3:0], 2'b00};
					root_q   <= root_nx;
					rt_rem_q <= rt_diff[RAD_W:0];
					rcnt_q   <= rcnt_q + 1'b1;
					if (rcnt_q == RC_W'(RAD_W - 1)) begin
						dist_q     <= root_nx;
						rem_q      <= {1'b0, rad - root_nx};
						dvs_q      <= rad;
						q_q        <= '0;
						dcnt_q     <= '0;
						is_scale_q <= 1'b1;
						state_q    <= ST_DIV;
					end
				end
				ST_DIV: begin
					q_q <= q_nx;
					if (dcnt_q == DC_W'(F) && is_scale_q) begin
						// scale done, first unit divide starts on x
						scale_q    <= q_nx;
						is_scale_q <= 1'b0;
						axis_q     <= '0;
						rem_q      <= {1'b0, amag_q[0]};
						dvs_q      <= dist_q;
						dcnt_q     <= '0;
					end else begin
						rem_q  <= dv_res;
						dcnt_q <= dcnt_q + 1'b1;
						if (dcnt_q == DC_W'(F)) begin
							unit_q  <= q_nx;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q  <= unit_q * scale_q;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q[axis_q] <= acc_nx;
					if (axis_q == 2'd2) begin
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end else begin
						axis_q  <= axis_nx;
						rem_q   <= {1'b0, amag_q[axis_nx]};
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						field_x     <= clip_v[0];
						field_y     <= clip_v[1];
						field_z     <= clip_v[2];
						saturated   <= |clip_s;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ sv/repulsive_field_accumulator_unit.sv @@
// repulsive field accumulator
// input channel (in_valid / in_stall) carries one word per item: command 0
// loads the query position and clears the three sums, command 1 is a map
// cell with its occupied flag; last = 1 asks for one result word after the
// item is applied. output channel (out_valid / out_stall) carries the summed
// field per axis, clipped to 32 bits, plus a saturated flag.
// the front end takes a word per cycle while the four-entry queue has room;
// far, empty cells without last are dropped there and cost nothing more.
// the back end handles a start or a dropped word with last in its idle
// state, runs a cell that fails the squared distance test through the
// square and sum states, and takes a near occupied cell on through the
// square root (one digit a cycle), the scale and three unit divides (one
// bit a cycle) and a multiply and saturating add per axis; the shared
// divider sets the rate, and a word is popped only when idle. a stalled
// result holds steady; the back end waits on it only at its next emit, the
// front keeps filling the queue. reset clears the query, the sums, the queue
// and sets influence_radius to 2.0 (register 0, byte address 0, apb port).
`default_nettype none
module repulsive_field_accumulator_unit import rfa_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      command,
	input  wire logic signed [COORD_W-1:0] coord_x,
	input  wire logic signed [COORD_W-1:0] coord_y,
	input  wire logic signed [COORD_W-1:0] coord_z,
	input  wire logic                      occupied,
	input  wire logic                      last,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [COORD_W-1:0]      field_x,
	output logic signed [COORD_W-1:0]      field_y,
	output logic signed [COORD_W-1:0]      field_z,
	output logic                           saturated,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [ADDR_W-1:0]         paddr,
	input  wire logic [31:0]               pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	logic [RAD_W-1:0] radius_q;
	logic             q_full, q_empty, push, pop;
	job_t             wjob, rjob;

	// register index is the word address
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1:2] == REG_RADIUS) ? {{(32 - RAD_W){1'b0}}, radius_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[ADDR_W-1:2] == REG_RADIUS) begin
			radius_q <= pwdata[RAD_W-1:0];
		end
	end

	// front: distance box test against the stored query
	rfa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.coord_x  (coord_x),
		.coord_y  (coord_y),
		.coord_z  (coord_z),
		.occupied (occupied),
		.last     (last),
		.rad      (radius_q),
		.q_full   (q_full),
		.push     (push),
		.job      (wjob)
	);

	rfa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wjob),
		.full   (q_full),
		.pop    (pop),
		.rdata  (rjob),
		.empty  (q_empty)
	);

	// back: root, divides, multiply, saturating sums, result register
	rfa_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rad       (radius_q),
		.q_empty   (q_empty),
		.job       (rjob),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.field_x   (field_x),
		.field_y   (field_y),
		.field_z   (field_z),
		.saturated (saturated)
	);
endmodule
`default_nettype wire
